// ===== design/pn3_pkg.sv =====
package pn3_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int VAL_W         = 8;
    localparam int COORD_W       = 24;
    localparam int NOISE_W       = 16;

    // fade curve 6t^5 - 15t^4 + 10t^3
    localparam int FADE_A = 6;
    localparam int FADE_B = 15;
    localparam int FADE_C = 10;

    // gradient select codes that reuse x as the second term
    localparam logic [3:0] GRAD_X_A = 4'd12;
    localparam logic [3:0] GRAD_X_B = 4'd14;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_EVAL = 1'b1
    } t_mode;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [VAL_W-1:0] t_val;

endpackage

// ===== design/pn3_perm_ram.sv =====
module pn3_perm_ram (
    input  logic          i_clk,
    input  logic          i_we,
    input  pn3_pkg::t_idx i_waddr,
    input  pn3_pkg::t_val i_wdata,
    input  logic          i_re,
    input  pn3_pkg::t_idx i_raddr,
    output pn3_pkg::t_val o_rdata
);
    import pn3_pkg::*;

    t_val r_mem [TABLE_ENTRIES];
    t_val r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/perlin_noise_3d.sv =====
// throughput: one point per cycle unless i_stall holds the output; the fade and
// blend multipliers and the three permutation table lookups each own their
// pipeline stage; load beats give no result
// reset (synchronous, active low) empties the pipeline; the permutation
// table is not cleared and must be loaded before it is read
module perlin_noise_3d #(
    parameter int FRAC_BITS = pn3_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_mode,
    input  logic [pn3_pkg::IDX_W-1:0]        i_table_index,
    input  logic [pn3_pkg::VAL_W-1:0]        i_table_value,
    input  logic signed [pn3_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [pn3_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [pn3_pkg::COORD_W-1:0] i_coord_z,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [pn3_pkg::NOISE_W-1:0]      o_noise_value
);
    import pn3_pkg::*;

    localparam int F    = FRAC_BITS;
    localparam int W    = F + 8;
    localparam int PW   = 2 * W;
    localparam int EXTW = COORD_W + IDX_W;
    localparam int SH_R = (F >= 15) ? F - 15 : 0;
    localparam int SH_L = (F < 15) ? 15 - F : 0;
    localparam int QW   = W + 8;

    typedef logic signed [W-1:0] t_fx;

    localparam t_fx FX_ONE  = t_fx'(1) <<< F;
    localparam t_fx FX_FADE_B = t_fx'(FADE_B) <<< F;
    localparam t_fx FX_FADE_C = t_fx'(FADE_C) <<< F;
    localparam logic [QW-1:0] Q_MAX = QW'((1 << NOISE_W) - 1);

    function automatic t_fx fx_mul(input t_fx a, input t_fx b);
        logic signed [PW-1:0] p;
        p = PW'(a) * PW'(b);
        return p[F+W-1:F];
    endfunction

    function automatic t_fx blend(input t_fx t, input t_fx a, input t_fx b);
        return a + fx_mul(t, b - a);
    endfunction

    function automatic t_fx grad(input logic [3:0] h, input t_fx x, input t_fx y,
                                 input t_fx z);
        t_fx gu;
        t_fx gv;
        gu = (h < 4'd8) ? x : y;
        if (h < 4'd4) begin
            gv = y;
        end else if (h == GRAD_X_A || h == GRAD_X_B) begin
            gv = x;
        end else begin
            gv = z;
        end
        return (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
    endfunction

    // stage handshake: a stage loads when empty or when its successor loads
    logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv_o;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_ov;
    logic accept;

    assign adv_o = !r_ov || !i_stall;
    assign adv7  = !r_v7 || adv_o;
    assign adv6  = !r_v6 || adv7;
    assign adv5  = !r_v5 || adv6;
    assign adv4  = !r_v4 || adv5;
    assign adv3  = !r_v3 || adv4;
    assign adv2  = !r_v2 || adv3;
    assign adv1  = !r_v1 || adv2;
    assign o_stall = !adv1;
    assign accept  = i_valid && adv1;

    // input split
    logic signed [EXTW-1:0] ext_x, ext_y, ext_z;
    t_idx cell_x, cell_y, cell_z;
    t_fx  frac_in [3];

    assign ext_x  = EXTW'(i_coord_x);
    assign ext_y  = EXTW'(i_coord_y);
    assign ext_z  = EXTW'(i_coord_z);
    assign cell_x = ext_x[F+IDX_W-1:F];
    assign cell_y = ext_y[F+IDX_W-1:F];
    assign cell_z = ext_z[F+IDX_W-1:F];
    assign frac_in[0] = t_fx'({1'b0, ext_x[F-1:0]});
    assign frac_in[1] = t_fx'({1'b0, ext_y[F-1:0]});
    assign frac_in[2] = t_fx'({1'b0, ext_z[F-1:0]});

    // stage 1
    t_mode r_m1;
    t_idx  r_tidx1, r_cy1, r_cz1;
    t_val  r_tval1;
    t_fx   r_fr1 [3];
    t_val  l1_q [2];

    // stage 2
    t_mode r_m2;
    t_idx  r_tidx2, r_cz2;
    t_val  r_tval2;
    t_fx   r_fr2 [3];
    t_fx   r_sq2 [3];
    t_fx   r_q2  [3];
    t_val  l2_q [4];

    // stage 3
    t_fx   r_fr3 [3];
    t_fx   r_cube3 [3];
    t_fx   r_poly3 [3];
    t_val  l3_q [8];

    // stage 4 to 7
    t_fx   r_fade4 [3];
    t_fx   r_g4 [8];
    t_fx   r_fade5 [2];
    t_fx   r_lx5 [4];
    t_fx   r_fade6;
    t_fx   r_ly6 [2];
    t_fx   r_res7;
    logic [NOISE_W-1:0] r_noise;

    // table copies, each written when a load beat leaves the stage that reads it
    t_idx l2_addr [4];
    t_idx l3_addr [8];

    genvar gi;
    generate
        for (gi = 0; gi < 2; gi++) begin : g_l1
            pn3_perm_ram u_ram (
                .i_clk   (i_clk),
                .i_we    (accept && i_mode == MODE_LOAD),
                .i_waddr (i_table_index),
                .i_wdata (i_table_value),
                .i_re    (adv1),
                .i_raddr (cell_x + IDX_W'(gi)),
                .o_rdata (l1_q[gi])
            );
        end
        for (gi = 0; gi < 4; gi++) begin : g_l2
            assign l2_addr[gi] = ((gi % 2) != 0 ? l1_q[1] : l1_q[0]) + r_cy1
                                 + IDX_W'(gi / 2);
            pn3_perm_ram u_ram (
                .i_clk   (i_clk),
                .i_we    (r_v1 && adv2 && r_m1 == MODE_LOAD),
                .i_waddr (r_tidx1),
                .i_wdata (r_tval1),
                .i_re    (adv2),
                .i_raddr (l2_addr[gi]),
                .o_rdata (l2_q[gi])
            );
        end
        for (gi = 0; gi < 8; gi++) begin : g_l3
            assign l3_addr[gi] = l2_q[gi % 4] + r_cz2 + IDX_W'(gi / 4);
            pn3_perm_ram u_ram (
                .i_clk   (i_clk),
                .i_we    (r_v2 && adv3 && r_m2 == MODE_LOAD),
                .i_waddr (r_tidx2),
                .i_wdata (r_tval2),
                .i_re    (adv3),
                .i_raddr (l3_addr[gi]),
                .o_rdata (l3_q[gi])
            );
        end
    endgenerate

    // valid bits; load beats retire after stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (adv1)  r_v1 <= i_valid;
            if (adv2)  r_v2 <= r_v1;
            if (adv3)  r_v3 <= r_v2 && r_m2 == MODE_EVAL;
            if (adv4)  r_v4 <= r_v3;
            if (adv5)  r_v5 <= r_v4;
            if (adv6)  r_v6 <= r_v5;
            if (adv7)  r_v7 <= r_v6;
            if (adv_o) r_ov <= r_v7;
        end
    end

    // corner offsets x-1, y-1, z-1
    t_fx fr3_m1 [3];
    t_fx gx, gy, gz;
    t_fx n_g [8];
    t_fx val;
    logic [QW-1:0] q_wide;
    logic [NOISE_W-1:0] n_noise;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            fr3_m1[k] = r_fr3[k] - FX_ONE;
        end
        for (int k = 0; k < 8; k++) begin
            gx = k[0] ? fr3_m1[0] : r_fr3[0];
            gy = k[1] ? fr3_m1[1] : r_fr3[1];
            gz = k[2] ? fr3_m1[2] : r_fr3[2];
            n_g[k] = grad(l3_q[k][3:0], gx, gy, gz);
        end
        val = r_res7 + FX_ONE;
        q_wide = ((QW'(val)) >> SH_R) << SH_L;
        if (val < 0) begin
            n_noise = '0;
        end else if (q_wide > Q_MAX) begin
            n_noise = Q_MAX[NOISE_W-1:0];
        end else begin
            n_noise = q_wide[NOISE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_m1    <= t_mode'(i_mode);
            r_tidx1 <= i_table_index;
            r_tval1 <= i_table_value;
            r_cy1   <= cell_y;
            r_cz1   <= cell_z;
            r_fr1   <= frac_in;
        end
        if (adv2) begin
            r_m2    <= r_m1;
            r_tidx2 <= r_tidx1;
            r_tval2 <= r_tval1;
            r_cz2   <= r_cz1;
            r_fr2   <= r_fr1;
            for (int k = 0; k < 3; k++) begin
                r_sq2[k] <= fx_mul(r_fr1[k], r_fr1[k]);
                r_q2[k]  <= fx_mul(r_fr1[k], t_fx'(FADE_A) * r_fr1[k] - FX_FADE_B);
            end
        end
        if (adv3) begin
            r_fr3 <= r_fr2;
            for (int k = 0; k < 3; k++) begin
                r_cube3[k] <= fx_mul(r_sq2[k], r_fr2[k]);
                r_poly3[k] <= r_q2[k] + FX_FADE_C;
            end
        end
        if (adv4) begin
            for (int k = 0; k < 3; k++) begin
                r_fade4[k] <= fx_mul(r_cube3[k], r_poly3[k]);
            end
            r_g4 <= n_g;
        end
        if (adv5) begin
            for (int k = 0; k < 4; k++) begin
                r_lx5[k] <= blend(r_fade4[0], r_g4[2*k], r_g4[2*k+1]);
            end
            r_fade5[0] <= r_fade4[1];
            r_fade5[1] <= r_fade4[2];
        end
        if (adv6) begin
            r_ly6[0] <= blend(r_fade5[0], r_lx5[0], r_lx5[1]);
            r_ly6[1] <= blend(r_fade5[0], r_lx5[2], r_lx5[3]);
            r_fade6  <= r_fade5[1];
        end
        if (adv7) begin
            r_res7 <= blend(r_fade6, r_ly6[0], r_ly6[1]);
        end
        if (adv_o) begin
            r_noise <= n_noise;
        end
    end

    assign o_valid       = r_ov;
    assign o_noise_value = r_noise;

    // input stalls only when every stage holds a beat
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && r_v6 && r_v7 && r_ov))
        else $error("input stalled with a free stage");

    a_load_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_mode == MODE_LOAD) |=> (r_v1 && r_m1 == MODE_LOAD))
        else $error("load beat lost at stage 1");

    a_hold_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !adv5) |=> r_v4)
        else $error("held beat dropped at stage 4");

endmodule

// ===== sim/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pn3_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam longint ONE = longint'(1) << FB;

    // predictor of the noise pipeline: holds the table and the expected values
    class noise_scoreboard;
        bit [7:0] perm_tab [256];
        logic [NOISE_W-1:0] pending [$];
        int mismatches = 0;
        int evals = 0;
        int loads = 0;
        int checked = 0;

        function longint fx_floor(longint p);
            return p >>> FB;
        endfunction

        function longint fade(longint t);
            longint t3;
            longint p;
            t3 = fx_floor(fx_floor(t * t) * t);
            p = fx_floor(t * (FADE_A * t - FADE_B * ONE)) + FADE_C * ONE;
            return fx_floor(t3 * p);
        endfunction

        function longint mix(longint t, longint a, longint b);
            return a + fx_floor(t * (b - a));
        endfunction

        function longint grad(int hash, longint x, longint y, longint z);
            bit [3:0] h;
            longint u;
            longint v;
            h = hash[3:0];
            u = (h < 8) ? x : y;
            v = (h < 4) ? y : ((h == GRAD_X_A || h == GRAD_X_B) ? x : z);
            return (h[0] ? -u : u) + (h[1] ? -v : v);
        endfunction

        function int pt(int i);
            return perm_tab[i & (TABLE_ENTRIES - 1)];
        endfunction

        function logic [NOISE_W-1:0] noise(logic signed [23:0] cx, logic signed [23:0] cy,
                                           logic signed [23:0] cz);
            int xi, yi, zi, a, aa, ab, b, ba, bb;
            longint x, y, z, u, v, w, x1, y1, z1, res, val, q;
            xi = (longint'(cx) >>> FB) & 255;
            yi = (longint'(cy) >>> FB) & 255;
            zi = (longint'(cz) >>> FB) & 255;
            x = longint'(cx) & (ONE - 1);
            y = longint'(cy) & (ONE - 1);
            z = longint'(cz) & (ONE - 1);
            u = fade(x); v = fade(y); w = fade(z);
            a = pt(xi) + yi; aa = pt(a) + zi; ab = pt(a + 1) + zi;
            b = pt(xi + 1) + yi; ba = pt(b) + zi; bb = pt(b + 1) + zi;
            x1 = x - ONE; y1 = y - ONE; z1 = z - ONE;
            res = mix(w,
                mix(v, mix(u, grad(pt(aa), x, y, z), grad(pt(ba), x1, y, z)),
                       mix(u, grad(pt(ab), x, y1, z), grad(pt(bb), x1, y1, z))),
                mix(v, mix(u, grad(pt(aa + 1), x, y, z1), grad(pt(ba + 1), x1, y, z1)),
                       mix(u, grad(pt(ab + 1), x, y1, z1), grad(pt(bb + 1), x1, y1, z1))));
            val = res + ONE;
            if (val < 0) return '0;
            q = (FB >= 15) ? (val >>> (FB - 15)) : (val <<< (15 - FB));
            if (q > 65535) q = 65535;
            return q[15:0];
        endfunction

        function void note_input(t_mode m, t_idx idx, t_val tv, logic signed [23:0] cx,
                                 logic signed [23:0] cy, logic signed [23:0] cz);
            if (m == MODE_LOAD) begin
                perm_tab[idx] = tv;
                loads++;
            end else begin
                pending.push_back(noise(cx, cy, cz));
                evals++;
            end
        endfunction

        function void check_result(logic [NOISE_W-1:0] got);
            logic [NOISE_W-1:0] want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat: noise %0d", got);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("noise mismatch: expected %0d got %0d", want, got);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    logic i_mode;
    logic [IDX_W-1:0] i_table_index;
    logic [VAL_W-1:0] i_table_value;
    logic signed [COORD_W-1:0] i_coord_x, i_coord_y, i_coord_z;
    logic o_valid;
    logic i_stall;
    logic [NOISE_W-1:0] o_noise_value;

    noise_scoreboard sb;
    bit calm_phase;

    perlin_noise_3d dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("== FAIL ==");
        $finish;
    end

    // output side: random stall outside the calm phase, checks each accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_noise_value);
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= !calm_phase && ($urandom_range(99) < 25);
    end

    task automatic send(t_mode m, t_idx idx, t_val tv, logic signed [23:0] cx,
                        logic signed [23:0] cy, logic signed [23:0] cz);
        while (!calm_phase && $urandom_range(99) < 25) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= m;
        i_table_index <= idx;
        i_table_value <= tv;
        i_coord_x <= cx;
        i_coord_y <= cy;
        i_coord_z <= cz;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(m, idx, tv, cx, cy, cz);
    endtask

    task automatic eval_point(logic signed [23:0] cx, logic signed [23:0] cy,
                              logic signed [23:0] cz);
        send(MODE_EVAL, t_idx'($urandom), t_val'($urandom), cx, cy, cz);
    endtask

    function automatic logic signed [23:0] rand_coord();
        case ($urandom_range(3))
            0: return 24'($urandom);
            1: return 24'($urandom_range(3 * ONE));
            2: return -24'($urandom_range(3 * ONE));
            default: return {$urandom_range(1) ? 8'h80 : 8'h7f, 16'($urandom)};
        endcase
    endfunction

    initial begin
        int order [256];
        int tmp, j;
        int timeout;
        sb = new();
        calm_phase = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_mode = MODE_LOAD;
        i_table_index = '0;
        i_table_value = '0;
        i_coord_x = '0;
        i_coord_y = '0;
        i_coord_z = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // fill the whole table from a shuffled list, extreme entries first; the result need not be a permutation
        for (int i = 0; i < 256; i++) order[i] = i;
        for (int i = 255; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = order[i]; order[i] = order[j]; order[j] = tmp;
        end
        send(MODE_LOAD, 8'd0, 8'd255, '0, '0, '0);
        send(MODE_LOAD, 8'd255, 8'd0, '0, '0, '0);
        for (int i = 1; i < 255; i++) send(MODE_LOAD, t_idx'(i), t_val'(order[i]), '0, '0, '0);

        // directed points: origin, lattice corners, coordinate extremes
        eval_point('0, '0, '0);
        eval_point(24'h7fffff, 24'h7fffff, 24'h7fffff);
        eval_point(24'sh800000, 24'sh800000, 24'sh800000);
        eval_point(24'h00ffff, 24'h00ffff, 24'h00ffff);
        eval_point(24'h008000, 24'h008000, 24'h008000);
        eval_point(-24'sd1, -24'sd1, -24'sd1);
        eval_point(24'hff0000, 24'h010000, 24'h7f0000);
        eval_point(24'h7fffff, 24'sh800000, '0);
        eval_point(24'h00c000, 24'h004000, 24'h00ffff);
        eval_point(24'h001000, 24'h00f000, 24'h000001);

        // long calm stretch, then random traffic with reloads mixed in
        calm_phase = 1;
        for (int i = 0; i < 300; i++) eval_point(rand_coord(), rand_coord(), rand_coord());
        calm_phase = 0;
        for (int i = 0; i < 1050; i++) begin
            if ($urandom_range(99) < 15)
                send(MODE_LOAD, t_idx'($urandom), t_val'($urandom), '0, '0, '0);
            else
                eval_point(rand_coord(), rand_coord(), rand_coord());
        end
        i_valid <= 0;

        timeout = 0;
        while (sb.pending.size() != 0 && timeout < 10000) begin
            @(posedge i_clk);
            timeout++;
        end
        repeat (20) @(posedge i_clk);
        $display("covered %0d table loads and %0d noise points, %0d results checked",
                 sb.loads, sb.evals, sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
design/pn3_pkg.sv
design/pn3_perm_ram.sv
design/perlin_noise_3d.sv
sim/testbench.sv
